// ===== hdl/fcfp_pkg.sv =====
// Package for the feedback color-field pixel block: sizes, codes, sine table.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package fcfp_pkg;

  localparam int MAX_DIM      = 256;
  localparam int NUM_COEFS    = 18;
  localparam int SINE_ENTRIES = 256;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ROW_W   = $clog2(MAX_DIM);
  localparam int SE_W    = $clog2(SINE_ENTRIES);
  localparam int SCL_W   = 14 + SE_W;
  localparam int COEF_IW = $clog2(NUM_COEFS);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;
  localparam int SIN_W      = 14;
  localparam int SUM_W      = 52;
  localparam int NUM_STAGES = 8;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_LOAD  = 2'd2
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCUS_GAIN = 1'b0,
    CFG_SLEW_LIMIT = 1'b1
  } cfg_index_t;

  localparam logic [13:0] FOCUS_GAIN_RST = 14'd3686;
  localparam logic [11:0] SLEW_LIMIT_RST = 12'd328;
  localparam logic signed [12:0] SEVEN_TENTHS = 13'sd2867;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DEN [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

  typedef logic [12:0] qsin_tab_t [0:SINE_ENTRIES];

  function automatic logic [12:0] table_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    logic signed [63:0] sum;
    x = (HALF_PI_Q30 * 64'(k)) / SINE_ENTRIES;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DEN[n];
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    r = ($unsigned(sum) + (64'd1 << 17)) >> 18;
    if (r > 64'd4096) r = 64'd4096;
    return 13'(r);
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t t;
    for (int k = 0; k <= SINE_ENTRIES; k++) t[k] = table_entry(k);
    return t;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

  function automatic logic signed [SIN_W-1:0] sine_of(input logic [15:0] ph);
    logic [1:0] quad;
    logic [SCL_W-1:0] scaled;
    logic [SE_W:0] idx;
    logic [SE_W:0] pick;
    logic signed [SIN_W-1:0] sv;
    quad = ph[15:14];
    scaled = SCL_W'(ph[13:0]) * SCL_W'(SINE_ENTRIES);
    idx = (SE_W + 1)'(scaled >> 14);
    if (idx > (SE_W + 1)'(SINE_ENTRIES)) idx = (SE_W + 1)'(SINE_ENTRIES);
    pick = quad[0] ? ((SE_W + 1)'(SINE_ENTRIES) - idx) : idx;
    sv = $signed({1'b0, QSIN[pick]});
    return quad[1] ? -sv : sv;
  endfunction

endpackage

// ===== hdl/fcfp_ifs.sv =====
// Valid/ready channel interfaces for request and result words.
// Depends on fcfp_pkg.
`timescale 1ns / 1ps

interface fcfp_req_if import fcfp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         row;
  logic [7:0]         col;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic [4:0]         coef_index;
  logic [15:0]        phase_value;
  logic [12:0]        velocity_value;

  modport source(output valid, req_type, row, col, pos_x, pos_y, coef_index,
                 phase_value, velocity_value, input ready);
  modport sink(input valid, req_type, row, col, pos_x, pos_y, coef_index,
               phase_value, velocity_value, output ready);
endinterface

interface fcfp_rsp_if;
  logic        valid;
  logic        ready;
  logic [12:0] red;
  logic [12:0] green;
  logic [12:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

// ===== hdl/feedback_color_field_pixel_top.sv =====
// Top level of the feedback color-field pixel generator.
// Depends on fcfp_pkg and fcfp_ifs.
`timescale 1ns / 1ps

// Pixel words run through an eight-stage pipeline plus an output register, and one
// word can be taken every cycle while nothing holds the input. A pixel word waits
// while an earlier pixel to the same color store entry is still in the pipeline,
// because the entry is read at entry and written at the last stage. A tick word
// waits until no pixel is in flight, then blocks input while the coefficients are
// rebuilt; load words and unused request codes wait only for a clear or rebuild.
// The whole pipeline holds while a result waits on the output. After reset the
// color store is cleared one entry per cycle, all 65536 entries, and no request
// word is taken until that ends.
module feedback_color_field_pixel_top import fcfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  fcfp_req_if.sink              req,
  fcfp_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [34:0] ONE_Q24 = 35'sd16777216;

  logic [13:0] focus_gain;
  logic [11:0] slew_limit;

  logic [15:0]              coef_phase    [NUM_COEFS];
  logic [12:0]              coef_velocity [NUM_COEFS];
  logic signed [15:0]       coef_value    [NUM_COEFS];
  logic signed [SIN_W-1:0]  sin_q         [NUM_COEFS];
  logic [15:0]              phase_next    [NUM_COEFS];
  logic signed [15:0]       value_next    [NUM_COEFS];
  logic                     tick_busy;

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic [47:0] mem [DEPTH];
  logic [47:0] rd_q;

  logic [NUM_STAGES:1] pv;
  logic [ADDR_W-1:0]   addr_s [1:NUM_STAGES];
  logic signed [15:0]  oc     [2:NUM_STAGES][3];

  logic signed [16:0] s1_x, s1_y, s2_x, s2_y, s3_x, s3_y;
  logic signed [33:0] s2_xx, s2_yy, s2_xy;
  logic signed [34:0] s3_xx1, s3_xx, s3_xy, s3_yym1, s3_yy, s3_1mxy;
  logic signed [34:0] op_a [3];
  logic signed [34:0] op_b [3];
  logic signed [15:0] op_oa [3];
  logic signed [15:0] op_ob [3];
  logic signed [32:0] s4_px [3];
  logic signed [32:0] s4_py [3];
  logic signed [50:0] s4_pa [3];
  logic signed [50:0] s4_pb [3];
  logic signed [31:0] s4_poa [3];
  logic signed [31:0] s4_pob [3];
  logic signed [SUM_W-1:0] s5_ps1 [3];
  logic signed [SUM_W-1:0] s5_ps2 [3];
  logic signed [SUM_W-1:0] s6_sum [3];
  logic signed [64:0] s7_prod [3];
  logic [64:0]        mag [3];
  logic [64:0]        rnd [3];
  logic signed [26:0] fresh_next [3];
  logic signed [26:0] s8_fresh [3];
  logic signed [27:0] d [3];
  logic signed [27:0] lim;
  logic signed [27:0] f28 [3];
  logic signed [15:0] f16 [3];
  logic signed [16:0] m17 [3];
  logic [12:0]        out_next [3];

  logic        out_valid;
  logic [12:0] red, green, blue;

  logic              adv, hazard, pipe_busy, acc;
  logic              is_pix, is_tick, is_load;
  logic [ROW_W-1:0]  row_i, col_i;
  logic [ADDR_W-1:0] req_addr;

  assign is_pix  = req.req_type == REQ_PIXEL;
  assign is_tick = req.req_type == REQ_TICK;
  assign is_load = req.req_type == REQ_LOAD;

  assign row_i    = ROW_W'(req.row % MAX_DIM);
  assign col_i    = ROW_W'(req.col % MAX_DIM);
  assign req_addr = ADDR_W'(row_i) * ADDR_W'(MAX_DIM) + ADDR_W'(col_i);

  assign adv       = !out_valid || rsp.ready;
  assign pipe_busy = |pv;

  always_comb begin
    hazard = 1'b0;
    for (int s = 1; s <= NUM_STAGES; s++) begin
      if (pv[s] && addr_s[s] == req_addr) hazard = 1'b1;
    end
  end

  always_comb begin
    if (clearing || tick_busy) req.ready = 1'b0;
    else if (is_pix) req.ready = adv && !hazard;
    else if (is_tick) req.ready = !pipe_busy;
    else req.ready = 1'b1;
  end

  assign acc = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_gain <= FOCUS_GAIN_RST;
      slew_limit <= SLEW_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCUS_GAIN: focus_gain <= cfg_data[13:0];
        CFG_SLEW_LIMIT: slew_limit <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COEFS; i++) begin
      logic signed [28:0] p;
      logic [28:0] pm;
      logic [28:0] pr;
      phase_next[i] = coef_phase[i] + 16'(coef_velocity[i]);
      p = sin_q[i] * $signed({1'b0, focus_gain});
      pm = p[28] ? 29'(-p) : 29'(p);
      pr = (pm + 29'd2048) >> 12;
      value_next[i] = p[28] ? -$signed(16'(pr)) : $signed(16'(pr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_busy <= 1'b0;
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_phase[i]    <= '0;
        coef_velocity[i] <= '0;
        coef_value[i]    <= '0;
        sin_q[i]         <= '0;
      end
    end else begin
      tick_busy <= acc && is_tick;
      if (acc && is_tick) begin
        for (int i = 0; i < NUM_COEFS; i++) begin
          coef_phase[i] <= phase_next[i];
          sin_q[i]      <= sine_of(phase_next[i]);
        end
      end else if (acc && is_load && req.coef_index < 5'(NUM_COEFS)) begin
        coef_phase[COEF_IW'(req.coef_index)]    <= req.phase_value;
        coef_velocity[COEF_IW'(req.coef_index)] <= req.velocity_value;
      end
      if (tick_busy) begin
        for (int i = 0; i < NUM_COEFS; i++) coef_value[i] <= value_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (adv && pv[NUM_STAGES]) begin
      mem[addr_s[NUM_STAGES]] <= {f16[2], f16[1], f16[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) rd_q <= mem[req_addr];
  end

  always_comb begin
    op_a[0] = s3_xx1;  op_b[0] = s3_xy;   op_oa[0] = oc[3][1]; op_ob[0] = oc[3][2];
    op_a[1] = s3_xx;   op_b[1] = s3_yym1; op_oa[1] = oc[3][0]; op_ob[1] = oc[3][2];
    op_a[2] = s3_1mxy; op_b[2] = s3_yy;   op_oa[2] = oc[3][0]; op_ob[2] = oc[3][1];
  end

  assign lim = $signed({16'd0, slew_limit});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = s7_prod[c][64] ? 65'(-s7_prod[c]) : 65'(s7_prod[c]);
      rnd[c] = (mag[c] + (65'd1 << 35)) >> 36;
      fresh_next[c] = s7_prod[c][64] ? -$signed(27'(rnd[c])) : $signed(27'(rnd[c]));

      d[c] = 28'(s8_fresh[c]) - 28'(oc[8][c]);
      if (d[c] > lim) f28[c] = 28'(oc[8][c]) + lim;
      else if (d[c] < -lim) f28[c] = 28'(oc[8][c]) - lim;
      else f28[c] = 28'(s8_fresh[c]);
      if (f28[c] > 28'sd32767) f16[c] = 16'sd32767;
      else if (f28[c] < -28'sd32768) f16[c] = -16'sd32768;
      else f16[c] = 16'(f28[c]);
      m17[c] = f16[c][15] ? -17'(f16[c]) : 17'(f16[c]);
      out_next[c] = (m17[c] > 17'sd4096) ? 13'd4096 : 13'(m17[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      pv        <= {pv[NUM_STAGES-1:1], acc && is_pix};
      out_valid <= pv[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr_s[1] <= req_addr;
      for (int s = 2; s <= NUM_STAGES; s++) addr_s[s] <= addr_s[s-1];
      s1_x <= req.pos_x;
      s1_y <= req.pos_y;

      s2_x  <= s1_x;
      s2_y  <= s1_y;
      s2_xx <= s1_x * s1_x;
      s2_yy <= s1_y * s1_y;
      s2_xy <= s1_x * s1_y;
      oc[2][0] <= $signed(rd_q[15:0]);
      oc[2][1] <= $signed(rd_q[31:16]);
      oc[2][2] <= $signed(rd_q[47:32]);
      for (int s = 3; s <= NUM_STAGES; s++) oc[s] <= oc[s-1];

      s3_x    <= s2_x;
      s3_y    <= s2_y;
      s3_xx   <= 35'(s2_xx);
      s3_yy   <= 35'(s2_yy);
      s3_xy   <= 35'(s2_xy);
      s3_xx1  <= 35'(s2_xx) + ONE_Q24;
      s3_yym1 <= 35'(s2_yy) - ONE_Q24;
      s3_1mxy <= ONE_Q24 - 35'(s2_xy);

      for (int c = 0; c < 3; c++) begin
        s4_px[c]  <= coef_value[6*c] * s3_x;
        s4_py[c]  <= coef_value[6*c+1] * s3_y;
        s4_pa[c]  <= coef_value[6*c+2] * op_a[c];
        s4_pb[c]  <= coef_value[6*c+3] * op_b[c];
        s4_poa[c] <= coef_value[6*c+4] * op_oa[c];
        s4_pob[c] <= coef_value[6*c+5] * op_ob[c];

        s5_ps1[c] <= SUM_W'(s4_pa[c]) + SUM_W'(s4_pb[c]);
        s5_ps2[c] <= (SUM_W'(s4_px[c]) + SUM_W'(s4_py[c]) + SUM_W'(s4_poa[c])
                      + SUM_W'(s4_pob[c])) <<< 12;

        s6_sum[c]   <= s5_ps1[c] + s5_ps2[c];
        s7_prod[c]  <= s6_sum[c] * SEVEN_TENTHS;
        s8_fresh[c] <= fresh_next[c];
      end

      if (pv[NUM_STAGES]) begin
        red   <= out_next[0];
        green <= out_next[1];
        blue  <= out_next[2];
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.red   = red;
  assign rsp.green = green;
  assign rsp.blue  = blue;

endmodule

// ===== hdl/fcfp_checker.sv =====
// Port-level checks for the feedback color-field pixel top level, and the bind.
// Depends on fcfp_pkg and feedback_color_field_pixel_top.
`timescale 1ns / 1ps

module fcfp_checker import fcfp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_type,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [12:0] red,
  input logic [12:0] green,
  input logic [12:0] blue
);

  // Colors leave as magnitudes no larger than one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> red <= 13'd4096 && green <= 13'd4096 && blue <= 13'd4096)
    else $error("result word above one");

  // Hold input at the start of the store clear after reset.
  a_clear: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during store clear");

  // Block input for the coefficient rebuild after a tick.
  a_tick: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_type == REQ_TICK |=> !req_ready)
    else $error("request taken during coefficient rebuild");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(red) && $stable(green)
      && $stable(blue))
    else $error("stalled result word changed");

endmodule

bind feedback_color_field_pixel_top fcfp_checker u_fcfp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .red       (rsp.red),
  .green     (rsp.green),
  .blue      (rsp.blue)
);
